FILE: src/pinhole_project_with_distortion_core_assert.svh
// assertion macros for the projection core
// needs clk and rst in scope where used
`ifndef PINHOLE_PROJECT_WITH_DISTORTION_CORE_ASSERT_SVH
`define PINHOLE_PROJECT_WITH_DISTORTION_CORE_ASSERT_SVH

// same-cycle implication
`define PHP_ASSERT_IMPL(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// next-cycle implication
`define PHP_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> conseq) else $error(msg);

`endif

FILE: src/php_pkg.sv
// shared types, constants and saturation helper for the projection core
// no dependencies
`default_nettype none
package php_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic signed [15:0] column;
    logic signed [15:0] row;
    logic               in_bounds;
  } proj_t;

  typedef struct packed {
    logic        [31:0] focal_x;
    logic        [31:0] focal_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic pos;
  } ctl_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_RADIAL_K1  = 3'd4,
    REG_RADIAL_K2  = 3'd5,
    REG_RADIAL_K3  = 3'd6,
    REG_TANGENTIAL = 3'd7
  } reg_index_t;

  localparam int DIV_STEPS = 48;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int DIST_LAT  = 8;
  localparam int PIX_LAT   = 3;
  localparam int CORE_LAT  = DIV_LAT + DIST_LAT + PIX_LAT;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    else if (v < -64'sh80000000) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/pinhole_project_with_distortion_core.sv
// top level of the pinhole projection core with lens distortion
// depends on php_pkg, php_divide, php_distort, php_pixel and the assertion macro header
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------------
//  point    | start, busy, point               | taken on a clock edge with start && !busy
//  result   | done, proj                       | one-cycle strobe, cannot be held off
//  config   | cfg_we, cfg_index, cfg_data      | written on any edge with cfg_we high
//
// one transaction per cycle, sustained; busy is never raised
// a point passes through the divider (one quotient bit per stage over the 48-bit
// dividend, then a saturating output register), the distortion multiplier chain and
// the focal scaling, offset and rounding stages
// synchronous reset clears the valid bits and all config registers but focal (set to 1.0)
// there is no back-pressure on results, so the pipeline never stalls
`default_nettype none
`include "pinhole_project_with_distortion_core_assert.svh"
module pinhole_project_with_distortion_core #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire php_pkg::point_t point,
  output logic                 done,
  output php_pkg::proj_t       proj,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [63:0]     cfg_data
);
  php_pkg::cfg_t      cfg;
  php_pkg::ctl_t      ctl_in, ctl_div, ctl_dist;
  logic signed [31:0] xn, yn, xd, yd;

  // fully pipelined, so never busy
  assign busy = 1'b0;

  // a point with non-positive depth still flows, but is zeroed at the output
  assign ctl_in.valid = start && !busy;
  assign ctl_in.pos   = !point.point_z[31] && (point.point_z != '0);

  // configuration registers; the user must write them only while idle, not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= 32'h0001_0000;
      cfg.focal_y  <= 32'h0001_0000;
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.k1       <= '0;
      cfg.k2       <= '0;
      cfg.k3       <= '0;
      cfg.p1       <= '0;
      cfg.p2       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        php_pkg::REG_FOCAL_X:    cfg.focal_x  <= cfg_data[31:0];
        php_pkg::REG_FOCAL_Y:    cfg.focal_y  <= cfg_data[31:0];
        php_pkg::REG_CENTER_X:   cfg.center_x <= cfg_data[31:0];
        php_pkg::REG_CENTER_Y:   cfg.center_y <= cfg_data[31:0];
        php_pkg::REG_RADIAL_K1:  cfg.k1       <= cfg_data[31:0];
        php_pkg::REG_RADIAL_K2:  cfg.k2       <= cfg_data[31:0];
        php_pkg::REG_RADIAL_K3:  cfg.k3       <= cfg_data[31:0];
        php_pkg::REG_TANGENTIAL: begin
          cfg.p1 <= cfg_data[31:0];
          cfg.p2 <= cfg_data[63:32];
        end
        default: ;
      endcase
    end
  end

  // perspective divide
  php_divide u_divide (
    .clk   (clk),
    .rst   (rst),
    .ctl_i (ctl_in),
    .pt    (point),
    .ctl_o (ctl_div),
    .xn    (xn),
    .yn    (yn)
  );

  // lens distortion
  php_distort u_distort (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .ctl_i (ctl_div),
    .xn_i  (xn),
    .yn_i  (yn),
    .ctl_o (ctl_dist),
    .xd    (xd),
    .yd    (yd)
  );

  // pixel mapping and output register
  php_pixel #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_pixel (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .ctl_i (ctl_dist),
    .xd    (xd),
    .yd    (yd),
    .done  (done),
    .proj  (proj)
  );

  // every result comes from a transaction accepted a fixed latency earlier
  `PHP_ASSERT_IMPL(a_done_latency, done, $past(start && !busy, php_pkg::CORE_LAT), "result without matching transaction")
endmodule
`default_nettype wire

FILE: src/php_divide.sv
// pipelined restoring divider: x*2^16/z and y*2^16/z, one quotient bit per stage
// depends on php_pkg
`default_nettype none
module php_divide (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire php_pkg::ctl_t   ctl_i,
  input  wire php_pkg::point_t pt,
  output php_pkg::ctl_t        ctl_o,
  output logic signed [31:0]   xn,
  output logic signed [31:0]   yn
);
  localparam int S = php_pkg::DIV_STEPS;

  logic [S-1:0]  rq [2][S];
  logic [30:0]   rm [2][S];
  logic [30:0]   dz [S];
  logic          ng [2][S];
  php_pkg::ctl_t cq [S];

  logic [31:0]  ax, ay;
  logic [S-1:0] mag [2];
  logic         sgn [2];

  assign ax     = pt.point_x[31] ? 32'(-pt.point_x) : pt.point_x;
  assign ay     = pt.point_y[31] ? 32'(-pt.point_y) : pt.point_y;
  assign mag[0] = S'({ax, 16'h0000});
  assign mag[1] = S'({ay, 16'h0000});
  assign sgn[0] = pt.point_x[31];
  assign sgn[1] = pt.point_y[31];

  function automatic logic signed [31:0] qsat(input logic [S-1:0] q, input logic n);
    if (!n) return (q[S-1:31] != '0) ? 32'sh7FFFFFFF : q[31:0];
    else if (q[S-1:32] != '0 || (q[31] && (q[30:0] != '0))) return 32'sh80000000;
    else return -q[31:0];
  endfunction

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [S-1:0]  rq_p [2];
    logic [30:0]   rm_p [2];
    logic          ng_p [2];
    logic [30:0]   dz_p;
    php_pkg::ctl_t c_p;
    logic [31:0]   sh [2];
    logic          ge [2];

    if (s == 0) begin : g_first
      assign dz_p = pt.point_z[30:0];
      assign c_p  = ctl_i;
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rq_p[l] = mag[l];
        assign rm_p[l] = '0;
        assign ng_p[l] = sgn[l];
      end
    end else begin : g_next
      assign dz_p = dz[s-1];
      assign c_p  = cq[s-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rq_p[l] = rq[l][s-1];
        assign rm_p[l] = rm[l][s-1];
        assign ng_p[l] = ng[l][s-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_step
      assign sh[l] = {rm_p[l], rq_p[l][S-1]};
      assign ge[l] = sh[l] >= {1'b0, dz_p};
      always_ff @(posedge clk) begin
        rm[l][s] <= ge[l] ? 31'(sh[l] - {1'b0, dz_p}) : sh[l][30:0];
        rq[l][s] <= {rq_p[l][S-2:0], ge[l]};
        ng[l][s] <= ng_p[l];
      end
    end

    always_ff @(posedge clk) begin
      dz[s] <= dz_p;
      if (rst) begin
        cq[s] <= '0;
      end else begin
        cq[s] <= c_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    xn <= qsat(rq[0][S-1], ng[0][S-1]);
    yn <= qsat(rq[1][S-1], ng[1][S-1]);
    if (rst) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= cq[S-1];
    end
  end
endmodule
`default_nettype wire

FILE: src/php_distort.sv
// radial and tangential distortion pipeline on normalised coordinates
// depends on php_pkg
`default_nettype none
module php_distort (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire php_pkg::cfg_t      cfg,
  input  wire php_pkg::ctl_t      ctl_i,
  input  wire logic signed [31:0] xn_i,
  input  wire logic signed [31:0] yn_i,
  output php_pkg::ctl_t           ctl_o,
  output logic signed [31:0]      xd,
  output logic signed [31:0]      yd
);
  php_pkg::ctl_t ctl_q [php_pkg::DIST_LAT];

  logic signed [31:0] x2_1, y2_1, xy_1, xn_1, yn_1;
  logic signed [31:0] r2_2, x2_2, y2_2, xy_2, xn_2, yn_2;
  logic signed [31:0] r4_3, tx_3, ty_3, r2_3, xy_3, xn_3, yn_3;
  logic signed [47:0] t1_3;
  logic signed [31:0] r6_4, xn_4, yn_4;
  logic signed [47:0] t1_4, t2_4;
  logic signed [39:0] ta_4, tb_4, tc_4, td_4;
  logic signed [47:0] t1_5, t2_5, t3_5;
  logic signed [39:0] ta_5, tb_5, tc_5, td_5;
  logic signed [31:0] xn_5, yn_5;
  logic signed [31:0] d_6, xn_6, yn_6;
  logic signed [39:0] ta_6, tb_6, tc_6, td_6;
  logic signed [39:0] ex_7, ey_7, ta_7, tb_7, tc_7, td_7;

  logic signed [63:0] m_xx, m_yy, m_xy, m_rr, m_k1, m_r6, m_k2;
  logic signed [63:0] m_a, m_b, m_c, m_d, m_k3, m_ex, m_ey;

  assign m_xx = xn_i * xn_i;
  assign m_yy = yn_i * yn_i;
  assign m_xy = xn_i * yn_i;
  assign m_rr = r2_2 * r2_2;
  assign m_k1 = cfg.k1 * r2_2;
  assign m_r6 = r4_3 * r2_3;
  assign m_k2 = cfg.k2 * r4_3;
  assign m_a  = cfg.p1 * xy_3;
  assign m_b  = cfg.p2 * tx_3;
  assign m_c  = cfg.p2 * xy_3;
  assign m_d  = cfg.p1 * ty_3;
  assign m_k3 = cfg.k3 * r6_4;
  assign m_ex = xn_6 * d_6;
  assign m_ey = yn_6 * d_6;

  always_ff @(posedge clk) begin
    // squares and cross term
    x2_1 <= php_pkg::sat32(m_xx >>> 16);
    y2_1 <= php_pkg::sat32(m_yy >>> 16);
    xy_1 <= php_pkg::sat32(m_xy >>> 16);
    xn_1 <= xn_i;
    yn_1 <= yn_i;
    // r squared
    r2_2 <= php_pkg::sat32(64'(x2_1) + 64'(y2_1));
    x2_2 <= x2_1;
    y2_2 <= y2_1;
    xy_2 <= xy_1;
    xn_2 <= xn_1;
    yn_2 <= yn_1;
    // r^4, tangential radii, k1 term
    r4_3 <= php_pkg::sat32(m_rr >>> 16);
    t1_3 <= 48'(m_k1 >>> 16);
    tx_3 <= php_pkg::sat32(64'(r2_2) + (64'(x2_2) <<< 1));
    ty_3 <= php_pkg::sat32(64'(r2_2) + (64'(y2_2) <<< 1));
    r2_3 <= r2_2;
    xy_3 <= xy_2;
    xn_3 <= xn_2;
    yn_3 <= yn_2;
    // r^6, k2 term, tangential products
    r6_4 <= php_pkg::sat32(m_r6 >>> 16);
    t1_4 <= t1_3;
    t2_4 <= 48'(m_k2 >>> 16);
    ta_4 <= 40'(m_a >>> 24);
    tb_4 <= 40'(m_b >>> 24);
    tc_4 <= 40'(m_c >>> 24);
    td_4 <= 40'(m_d >>> 24);
    xn_4 <= xn_3;
    yn_4 <= yn_3;
    // k3 term
    t1_5 <= t1_4;
    t2_5 <= t2_4;
    t3_5 <= 48'(m_k3 >>> 16);
    ta_5 <= ta_4;
    tb_5 <= tb_4;
    tc_5 <= tc_4;
    td_5 <= td_4;
    xn_5 <= xn_4;
    yn_5 <= yn_4;
    // radial factor, q8.24
    d_6  <= php_pkg::sat32(64'sh1000000 + 64'(t1_5) + 64'(t2_5) + 64'(t3_5));
    ta_6 <= ta_5;
    tb_6 <= tb_5;
    tc_6 <= tc_5;
    td_6 <= td_5;
    xn_6 <= xn_5;
    yn_6 <= yn_5;
    // radial scaling
    ex_7 <= 40'(m_ex >>> 24);
    ey_7 <= 40'(m_ey >>> 24);
    ta_7 <= ta_6;
    tb_7 <= tb_6;
    tc_7 <= tc_6;
    td_7 <= td_6;
    // final sums
    xd <= php_pkg::sat32(64'(ex_7) + (64'(ta_7) <<< 1) + 64'(tb_7));
    yd <= php_pkg::sat32(64'(ey_7) + (64'(tc_7) <<< 1) + 64'(td_7));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < php_pkg::DIST_LAT; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < php_pkg::DIST_LAT; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  assign ctl_o = ctl_q[php_pkg::DIST_LAT-1];
endmodule
`default_nettype wire

FILE: src/php_pixel.sv
// focal scaling, principal point, rounding to pixel indices and bounds check
// depends on php_pkg and the assertion macro header
`default_nettype none
`include "pinhole_project_with_distortion_core_assert.svh"
module php_pixel #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire php_pkg::cfg_t      cfg,
  input  wire php_pkg::ctl_t      ctl_i,
  input  wire logic signed [31:0] xd,
  input  wire logic signed [31:0] yd,
  output logic                    done,
  output php_pkg::proj_t          proj
);
  php_pkg::ctl_t      c9, c10;
  logic signed [64:0] m_fx, m_fy;
  logic signed [48:0] fx_9, fy_9;
  logic signed [31:0] px_10, py_10;
  logic signed [15:0] col_n, row_n;
  logic               pos_q;

  function automatic logic signed [15:0] to_index(input logic signed [31:0] p);
    logic signed [33:0] v;
    logic        [33:0] a;
    logic        [17:0] t;
    v = 34'(p) + 34'sd32768;
    a = v[33] ? 34'(-v) : 34'(v);
    t = a[33:16];
    if (!v[33]) return (t > 18'd32767) ? 16'sh7FFF : 16'(t);
    else return -(16'(t));
  endfunction

  assign m_fx  = $signed({1'b0, cfg.focal_x}) * xd;
  assign m_fy  = $signed({1'b0, cfg.focal_y}) * yd;
  assign col_n = to_index(px_10);
  assign row_n = to_index(py_10);

  always_ff @(posedge clk) begin
    fx_9  <= 49'(m_fx >>> 16);
    fy_9  <= 49'(m_fy >>> 16);
    px_10 <= php_pkg::sat32(64'(fx_9) + 64'(cfg.center_x));
    py_10 <= php_pkg::sat32(64'(fy_9) + 64'(cfg.center_y));
    pos_q <= c10.pos;
    if (c10.pos) begin
      proj.pixel_x   <= px_10;
      proj.pixel_y   <= py_10;
      proj.column    <= col_n;
      proj.row       <= row_n;
      proj.in_bounds <= !col_n[15] && ({1'b0, col_n[14:0]} < 16'(IMAGE_WIDTH))
                     && !row_n[15] && ({1'b0, row_n[14:0]} < 16'(IMAGE_HEIGHT));
    end else begin
      proj <= '0;
    end
    if (rst) begin
      c9   <= '0;
      c10  <= '0;
      done <= 1'b0;
    end else begin
      c9   <= ctl_i;
      c10  <= c9;
      done <= c10.valid;
    end
  end

  `PHP_ASSERT_IMPL(a_no_depth_zero, done && !pos_q, proj.pixel_x == '0 && proj.pixel_y == '0 && proj.column == '0 && proj.row == '0 && !proj.in_bounds, "non-positive depth gave a non-zero result")
  `PHP_ASSERT_IMPL(a_bounds_sign, done && proj.in_bounds, pos_q && !proj.column[15] && !proj.row[15], "in-bounds flag with negative index")
  `PHP_ASSERT_NEXT(a_stage_flow, ctl_i.valid, ##2 done, "transaction lost in output stages")
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// self-checking bench for the pinhole projection core with lens distortion
// depends on php_pkg and pinhole_project_with_distortion_core; a directed table then random points
// every accepted transaction is checked against an in-bench projection predictor or a typed result
`timescale 1ns / 100ps
module testbench;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  php_pkg::point_t  point = '0;
  logic             done;
  php_pkg::proj_t   proj;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = php_pkg::REG_FOCAL_X;
  logic [63:0]      cfg_data = '0;

  pinhole_project_with_distortion_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .proj(proj), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the camera registers
  logic [31:0] cam_fx, cam_fy, cam_cx, cam_cy, cam_k1, cam_k2, cam_k3;
  logic [63:0] cam_tang;

  php_pkg::proj_t pending_proj[$];
  int    errors = 0;
  int    idle_pct = 0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // projection of one camera-space point under the current registers
  function automatic php_pkg::proj_t project_point(input php_pkg::point_t p);
    longint px, py, pz, k1, k2, k3, p1, p2;
    longint xn, yn, x2, y2, xy, r2, r4, r6, d, tx, ty, xd, yd, pix_x, pix_y, col, row;
    php_pkg::proj_t r;
    r = '0;
    px = sx(p.point_x);
    py = sx(p.point_y);
    pz = sx(p.point_z);
    // depth at or below zero gives an all-zero, out-of-bounds result
    if (pz > 0) begin
      k1 = sx(cam_k1); k2 = sx(cam_k2); k3 = sx(cam_k3);
      p1 = sx(cam_tang[31:0]); p2 = sx(cam_tang[63:32]);
      xn = clamp32((px * 65536) / pz);
      yn = clamp32((py * 65536) / pz);
      x2 = clamp32((xn * xn) >>> 16);
      y2 = clamp32((yn * yn) >>> 16);
      xy = clamp32((xn * yn) >>> 16);
      r2 = clamp32(x2 + y2);
      r4 = clamp32((r2 * r2) >>> 16);
      r6 = clamp32((r4 * r2) >>> 16);
      d  = clamp32((64'sd1 <<< 24) + ((k1 * r2) >>> 16) + ((k2 * r4) >>> 16)
                   + ((k3 * r6) >>> 16));
      tx = clamp32(r2 + 2 * x2);
      ty = clamp32(r2 + 2 * y2);
      // y distortion takes the undistorted x through xy
      xd = clamp32(((xn * d) >>> 24) + 2 * ((p1 * xy) >>> 24) + ((p2 * tx) >>> 24));
      yd = clamp32(((yn * d) >>> 24) + 2 * ((p2 * xy) >>> 24) + ((p1 * ty) >>> 24));
      pix_x = clamp32(((longint'({32'b0, cam_fx}) * xd) >>> 16) + sx(cam_cx));
      pix_y = clamp32(((longint'({32'b0, cam_fy}) * yd) >>> 16) + sx(cam_cy));
      // add one half, then truncate toward zero, then clamp to 16 bits
      col = (pix_x + 32768) / 65536;
      row = (pix_y + 32768) / 65536;
      if (col > 32767) col = 32767;
      if (col < -32768) col = -32768;
      if (row > 32767) row = 32767;
      if (row < -32768) row = -32768;
      r.pixel_x   = pix_x[31:0];
      r.pixel_y   = pix_y[31:0];
      r.column    = col[15:0];
      r.row       = row[15:0];
      r.in_bounds = (col >= 0 && col < 640 && row >= 0 && row < 480);
    end
    return r;
  endfunction

  // check every result strobe against the oldest pending projection
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_proj.size() == 0) begin
        $display("%0t: unexpected result %h", $time, proj);
        errors++;
      end else begin
        php_pkg::proj_t e;
        e = pending_proj.pop_front();
        if (proj.pixel_x !== e.pixel_x) begin
          $display("%0t: pixel_x expected %h actual %h", $time, e.pixel_x, proj.pixel_x);
          errors++;
        end
        if (proj.pixel_y !== e.pixel_y) begin
          $display("%0t: pixel_y expected %h actual %h", $time, e.pixel_y, proj.pixel_y);
          errors++;
        end
        if (proj.column !== e.column) begin
          $display("%0t: column expected %h actual %h", $time, e.column, proj.column);
          errors++;
        end
        if (proj.row !== e.row) begin
          $display("%0t: row expected %h actual %h", $time, e.row, proj.row);
          errors++;
        end
        if (proj.in_bounds !== e.in_bounds) begin
          $display("%0t: in_bounds expected %b actual %b", $time, e.in_bounds,
                   proj.in_bounds);
          errors++;
        end
      end
    end
  end

  // one point transaction; called just after a rising edge
  task automatic send_point(input php_pkg::point_t p, input php_pkg::proj_t e);
    bit ok;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    // busy is tied low in the core, so mid-cycle sampling is stable
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
    pending_proj.push_back(e);
  endtask

  // one register write; the caller drops the write enable after the last one
  task automatic write_reg(input php_pkg::reg_index_t idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      php_pkg::REG_FOCAL_X:    cam_fx = v[31:0];
      php_pkg::REG_FOCAL_Y:    cam_fy = v[31:0];
      php_pkg::REG_CENTER_X:   cam_cx = v[31:0];
      php_pkg::REG_CENTER_Y:   cam_cy = v[31:0];
      php_pkg::REG_RADIAL_K1:  cam_k1 = v[31:0];
      php_pkg::REG_RADIAL_K2:  cam_k2 = v[31:0];
      php_pkg::REG_RADIAL_K3:  cam_k3 = v[31:0];
      php_pkg::REG_TANGENTIAL: cam_tang = v;
      default: ;
    endcase
  endtask

  // wait for the pipeline to drain before touching the registers
  task automatic drain_pipe;
    start <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk);
    repeat (php_pkg::CORE_LAT + 5) @(posedge clk);
  endtask

  task automatic load_camera(input int setting);
    logic [63:0] hi;
    hi = {$urandom, 32'h0};
    case (setting)
      0: begin
        // a plausible VGA camera with mild barrel distortion
        write_reg(php_pkg::REG_FOCAL_X, hi | 64'd32768000);
        write_reg(php_pkg::REG_FOCAL_Y, hi | 64'd32768000);
        write_reg(php_pkg::REG_CENTER_X, hi | 64'd20971520);
        write_reg(php_pkg::REG_CENTER_Y, hi | 64'd15728640);
        write_reg(php_pkg::REG_RADIAL_K1, hi | 64'(32'hFFCCCCCD));
        write_reg(php_pkg::REG_RADIAL_K2, hi | 64'd838861);
        write_reg(php_pkg::REG_RADIAL_K3, hi | 64'd16777);
        write_reg(php_pkg::REG_TANGENTIAL, {32'hFFFFBE77, 32'h00004189});
      end
      1: begin
        // register extremes
        write_reg(php_pkg::REG_FOCAL_X, hi | 64'hFFFFFFFF);
        write_reg(php_pkg::REG_FOCAL_Y, hi);
        write_reg(php_pkg::REG_CENTER_X, hi | 64'h7FFFFFFF);
        write_reg(php_pkg::REG_CENTER_Y, hi | 64'h80000000);
        write_reg(php_pkg::REG_RADIAL_K1, hi | 64'h7FFFFFFF);
        write_reg(php_pkg::REG_RADIAL_K2, hi | 64'h80000000);
        write_reg(php_pkg::REG_RADIAL_K3, hi | 64'h7FFFFFFF);
        write_reg(php_pkg::REG_TANGENTIAL, {32'h80000000, 32'h7FFFFFFF});
      end
      2: begin
        // extremes the other way round
        write_reg(php_pkg::REG_FOCAL_X, hi);
        write_reg(php_pkg::REG_FOCAL_Y, hi | 64'hFFFFFFFF);
        write_reg(php_pkg::REG_CENTER_X, hi | 64'h80000000);
        write_reg(php_pkg::REG_CENTER_Y, hi | 64'h7FFFFFFF);
        write_reg(php_pkg::REG_RADIAL_K1, hi | 64'h80000000);
        write_reg(php_pkg::REG_RADIAL_K2, hi | 64'h7FFFFFFF);
        write_reg(php_pkg::REG_RADIAL_K3, hi | 64'h80000000);
        write_reg(php_pkg::REG_TANGENTIAL, {32'h7FFFFFFF, 32'h80000000});
      end
      3, 5: begin
        // moderate random camera
        write_reg(php_pkg::REG_FOCAL_X, hi | 64'($urandom_range(1 << 20, 1 << 27)));
        write_reg(php_pkg::REG_FOCAL_Y, hi | 64'($urandom_range(1 << 20, 1 << 27)));
        write_reg(php_pkg::REG_CENTER_X, hi | 64'($urandom_range(0, 640 << 16)));
        write_reg(php_pkg::REG_CENTER_Y, hi | 64'($urandom_range(0, 480 << 16)));
        write_reg(php_pkg::REG_RADIAL_K1,
                  hi | 64'(32'($urandom_range(0, 1 << 23)) - 32'(1 << 22)));
        write_reg(php_pkg::REG_RADIAL_K2,
                  hi | 64'(32'($urandom_range(0, 1 << 21)) - 32'(1 << 20)));
        write_reg(php_pkg::REG_RADIAL_K3,
                  hi | 64'(32'($urandom_range(0, 1 << 19)) - 32'(1 << 18)));
        write_reg(php_pkg::REG_TANGENTIAL,
                  {32'($urandom_range(0, 1 << 17)) - 32'(1 << 16),
                   32'($urandom_range(0, 1 << 17)) - 32'(1 << 16)});
      end
      default: begin
        // fully random registers
        write_reg(php_pkg::REG_FOCAL_X, {$urandom, $urandom});
        write_reg(php_pkg::REG_FOCAL_Y, {$urandom, $urandom});
        write_reg(php_pkg::REG_CENTER_X, {$urandom, $urandom});
        write_reg(php_pkg::REG_CENTER_Y, {$urandom, $urandom});
        write_reg(php_pkg::REG_RADIAL_K1, {$urandom, $urandom});
        write_reg(php_pkg::REG_RADIAL_K2, {$urandom, $urandom});
        write_reg(php_pkg::REG_RADIAL_K3, {$urandom, $urandom});
        write_reg(php_pkg::REG_TANGENTIAL, {$urandom, $urandom});
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  function automatic php_pkg::point_t random_point();
    php_pkg::point_t p;
    logic [31:0] z;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: begin
        // point in front of the camera within a plausible field of view
        z = $urandom_range(1 << 14, 1 << 24);
        p.point_z = z;
        p.point_x = 32'($urandom_range(0, 2 * z)) - z;
        p.point_y = 32'($urandom_range(0, 2 * z)) - z;
      end
      7: p = {$urandom, $urandom, $urandom};
      8: begin
        // depth at or below zero
        p.point_x = $urandom;
        p.point_y = $urandom;
        p.point_z = ($urandom_range(0, 1)) ? 32'h0 : (32'h80000000 | $urandom);
      end
      default: begin
        // tiny depth to drive the stages toward saturation
        p.point_x = $urandom;
        p.point_y = $urandom;
        p.point_z = $urandom_range(1, 255);
      end
    endcase
    return p;
  endfunction

  typedef struct {
    php_pkg::point_t pt;
    bit              typed;
    php_pkg::proj_t  res;
  } stim_row_t;

  localparam int MAX = 32'h7FFFFFFF;
  localparam int MIN = 32'h80000000;

  // directed table, run with the reset registers
  stim_row_t directed_rows[] = '{
    '{'{32'sd0, 32'sd0, 32'sd65536}, 1'b1, '{32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{'{32'sd65536, 32'sd65536, 32'sd0}, 1'b1, '0},
    '{'{32'sd65536, 32'sd65536, -32'sd1}, 1'b1, '0},
    '{'{MAX, MAX, MIN}, 1'b1, '0},
    '{'{MIN, MIN, 32'sd0}, 1'b1, '0},
    '{'{MAX, MAX, 32'sd1}, 1'b0, '0},
    '{'{MIN, MIN, 32'sd1}, 1'b0, '0},
    '{'{MAX, MIN, 32'sd1}, 1'b0, '0},
    '{'{32'sd0, 32'sd0, MAX}, 1'b0, '0},
    '{'{MAX, MAX, MAX}, 1'b0, '0},
    '{'{MIN, MIN, MAX}, 1'b0, '0},
    '{'{32'sd65536, 32'sd131072, 32'sd65536}, 1'b0, '0},
    '{'{-32'sd65536, -32'sd32768, 32'sd65536}, 1'b0, '0},
    '{'{32'sd32768, 32'sd32767, 32'sd65536}, 1'b0, '0},
    '{'{-32'sd32768, -32'sd32769, 32'sd65536}, 1'b0, '0},
    '{'{32'sd1, -32'sd1, 32'sd3}, 1'b0, '0},
    '{'{32'h12345678, 32'hEDCBA987, 32'h00010000}, 1'b0, '0}
  };

  initial begin
    cam_fx = 32'd65536; cam_fy = 32'd65536;
    cam_cx = '0; cam_cy = '0; cam_k1 = '0; cam_k2 = '0; cam_k3 = '0;
    cam_tang = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 22;
    foreach (directed_rows[i])
      send_point(directed_rows[i].pt,
                 directed_rows[i].typed ? directed_rows[i].res
                                        : project_point(directed_rows[i].pt));

    // six camera settings, idling heavy on the sender only in the middle
    for (int ph = 0; ph < 6; ph++) begin
      drain_pipe();
      load_camera(ph);
      idle_pct = (ph < 2) ? 22 : (ph < 4) ? 74 : 0;
      for (int n = 0; n < 190; n++) begin
        php_pkg::point_t p;
        p = random_point();
        send_point(p, project_point(p));
      end
    end
    start <= 1'b0;

    while (pending_proj.size() != 0) @(posedge clk);
    repeat (php_pkg::CORE_LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("pinhole_project_with_distortion_core: match");
    end else begin
      $display("pinhole_project_with_distortion_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pinhole_project_with_distortion_core: mismatch");
    $finish;
  end

endmodule
